// File: rtl/core/gpe_pkg.sv
package gpe_pkg;

   localparam int FRAC_BITS_DEF = 16;
   localparam int QUEUE_DEPTH   = 8;

   // Configuration register indexes.
   localparam logic [7:0] CSR_MODE   = 8'd0;
   localparam logic [7:0] CSR_STRT_X = 8'd1;
   localparam logic [7:0] CSR_STRT_Y = 8'd2;
   localparam logic [7:0] CSR_STRT_R = 8'd3;
   localparam logic [7:0] CSR_END_X  = 8'd4;
   localparam logic [7:0] CSR_END_Y  = 8'd5;
   localparam logic [7:0] CSR_END_R  = 8'd6;
   localparam logic [7:0] CSR_DOMAIN = 8'd7;

   typedef struct packed {
      logic [2:0]         mode;
      logic signed [31:0] start_x;
      logic signed [31:0] start_y;
      logic signed [31:0] start_r;
      logic signed [31:0] end_x;
      logic signed [31:0] end_y;
      logic signed [31:0] end_r;
      logic signed [31:0] dom_lo;
      logic signed [31:0] dom_hi;
   } gpe_cfg_type;

   // Classified item: quadratic coefficients on the reduced operands.
   typedef struct packed {
      logic               radial;
      logic signed [63:0] a;
      logic signed [63:0] bp;
      logic signed [63:0] c;
      logic signed [30:0] r0;
      logic signed [30:0] dr;
   } gpe_item_type;

endpackage

// File: rtl/core/gpe_front.sv
module gpe_front import gpe_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   input  logic               accept,
   input  logic signed [31:0] point_x,
   input  logic signed [31:0] point_y,
   input  gpe_cfg_type        cfg,
   output logic               item_valid,
   output gpe_item_type       item
);

   logic               va_ff, vb_ff, vc_ff;
   logic               rad_a_ff, rad_b_ff, rad_c_ff;
   logic signed [32:0] dx_a_ff, dy_a_ff, dr_a_ff, px_a_ff, py_a_ff, r0_a_ff;
   logic signed [30:0] dx_b_ff, dy_b_ff, dr_b_ff, px_b_ff, py_b_ff, r0_b_ff;
   logic signed [30:0] r0_c_ff, dr_c_ff;
   logic signed [61:0] p_dxdx_ff, p_dydy_ff, p_drdr_ff, p_pxdx_ff, p_pydy_ff;
   logic signed [61:0] p_r0dr_ff, p_pxpx_ff, p_pypy_ff, p_r0r0_ff;
   logic               fit0, fit1;
   logic [1:0]         k_sel;

   function automatic logic fits0(input logic signed [32:0] v);
      return (v[32:30] == 3'b000) || (v[32:30] == 3'b111);
   endfunction

   function automatic logic fits1(input logic signed [32:0] v);
      return v[32] == v[31];
   endfunction

   function automatic logic signed [30:0] shr(input logic signed [32:0] v,
                                              input logic [1:0] k);
      logic signed [32:0] r;
      r = v >>> k;
      return r[30:0];
   endfunction

   always_comb begin
      fit0 = fits0(dx_a_ff) && fits0(dy_a_ff) && fits0(px_a_ff) && fits0(py_a_ff);
      fit1 = fits1(dx_a_ff) && fits1(dy_a_ff) && fits1(px_a_ff) && fits1(py_a_ff);
      if (rad_a_ff) begin
         fit0 = fit0 && fits0(dr_a_ff) && fits0(r0_a_ff);
         fit1 = fit1 && fits1(dr_a_ff) && fits1(r0_a_ff);
      end
      k_sel = fit0 ? 2'd0 : (fit1 ? 2'd1 : 2'd2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         va_ff <= 1'b0;
         vb_ff <= 1'b0;
         vc_ff <= 1'b0;
      end else begin
         va_ff <= accept;
         vb_ff <= va_ff;
         vc_ff <= vb_ff;
      end
      rad_a_ff <= cfg.mode[0];
      dx_a_ff  <= 33'(cfg.end_x) - 33'(cfg.start_x);
      dy_a_ff  <= 33'(cfg.end_y) - 33'(cfg.start_y);
      dr_a_ff  <= 33'(cfg.end_r) - 33'(cfg.start_r);
      px_a_ff  <= 33'(point_x) - 33'(cfg.start_x);
      py_a_ff  <= 33'(point_y) - 33'(cfg.start_y);
      r0_a_ff  <= 33'(cfg.start_r);

      rad_b_ff <= rad_a_ff;
      dx_b_ff  <= shr(dx_a_ff, k_sel);
      dy_b_ff  <= shr(dy_a_ff, k_sel);
      dr_b_ff  <= shr(dr_a_ff, k_sel);
      px_b_ff  <= shr(px_a_ff, k_sel);
      py_b_ff  <= shr(py_a_ff, k_sel);
      r0_b_ff  <= shr(r0_a_ff, k_sel);

      rad_c_ff  <= rad_b_ff;
      r0_c_ff   <= r0_b_ff;
      dr_c_ff   <= dr_b_ff;
      p_dxdx_ff <= dx_b_ff * dx_b_ff;
      p_dydy_ff <= dy_b_ff * dy_b_ff;
      p_drdr_ff <= dr_b_ff * dr_b_ff;
      p_pxdx_ff <= px_b_ff * dx_b_ff;
      p_pydy_ff <= py_b_ff * dy_b_ff;
      p_r0dr_ff <= r0_b_ff * dr_b_ff;
      p_pxpx_ff <= px_b_ff * px_b_ff;
      p_pypy_ff <= py_b_ff * py_b_ff;
      p_r0r0_ff <= r0_b_ff * r0_b_ff;
   end

   always_comb begin
      item_valid  = vc_ff;
      item.radial = rad_c_ff;
      item.r0     = r0_c_ff;
      item.dr     = dr_c_ff;
      item.a      = 64'(p_dxdx_ff) + 64'(p_dydy_ff);
      item.bp     = 64'(p_pxdx_ff) + 64'(p_pydy_ff);
      item.c      = 64'(p_pxpx_ff) + 64'(p_pypy_ff) - 64'(p_r0r0_ff);
      if (rad_c_ff) begin
         item.a  = item.a - 64'(p_drdr_ff);
         item.bp = item.bp + 64'(p_r0dr_ff);
      end
   end

endmodule

// File: rtl/core/gpe_queue.sv
module gpe_queue import gpe_pkg::*; #(
   parameter int DEPTH = QUEUE_DEPTH
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  gpe_item_type push_data,
   input  logic         pop,
   output logic         empty,
   output gpe_item_type rd_data
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   gpe_item_type    mem [DEPTH];
   gpe_item_type    rd_data_ff;
   logic [AW-1:0]   wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]   count_ff, count_in;

   function automatic logic [AW-1:0] wrap_inc(input logic [AW-1:0] p);
      return (p == AW'(DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   always_comb begin
      wr_ptr_in = push ? wrap_inc(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? wrap_inc(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
      if (pop) begin
         rd_data_ff <= mem[rd_ptr_ff];
      end
   end

   assign empty   = (count_ff == '0);
   assign rd_data = rd_data_ff;

endmodule

// File: rtl/core/gpe_back.sv
module gpe_back import gpe_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  gpe_cfg_type        cfg,
   input  logic               q_empty,
   input  gpe_item_type       q_data,
   output logic               q_pop,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_param_t,
   output logic               rsp_covered
);

   localparam int NW = 66;
   localparam int DW = NW + 32;

   localparam logic [3:0] ST_IDLE  = 4'd0;
   localparam logic [3:0] ST_LOAD  = 4'd1;
   localparam logic [3:0] ST_MUL   = 4'd2;
   localparam logic [3:0] ST_DISC  = 4'd3;
   localparam logic [3:0] ST_SQRT  = 4'd4;
   localparam logic [3:0] ST_DSAT  = 4'd5;
   localparam logic [3:0] ST_DLOOP = 4'd6;
   localparam logic [3:0] ST_CHK1  = 4'd7;
   localparam logic [3:0] ST_CHK2  = 4'd8;
   localparam logic [3:0] ST_MAP1  = 4'd9;
   localparam logic [3:0] ST_MAP2  = 4'd10;

   localparam logic signed [31:0] S_ONE = 32'sd1 <<< FRAC_BITS;
   localparam logic signed [31:0] S_MAX = 32'sh7FFF_FFFF;

   logic [3:0]            state_ff, state_in;
   logic                  radial_ff, radial_in;
   logic signed [63:0]    a_ff, a_in, bp_ff, bp_in, c_ff, c_in;
   logic signed [30:0]    r0_ff, r0_in, dr_ff, dr_in;
   logic [127:0]          mp_ff, mp_in, mq_ff, mq_in;
   logic [63:0]           mm_ff, mm_in, mn_ff, mn_in;
   logic [6:0]            cnt_ff, cnt_in;
   logic [125:0]          sqn_ff, sqn_in;
   logic [66:0]           rem_ff, rem_in;
   logic [62:0]           root_ff, root_in;
   logic signed [NW-1:0]  num0_ff, num0_in, num1_ff, num1_in, den_ff, den_in;
   logic                  two_ff, two_in, cidx_ff, cidx_in, neg_ff, neg_in;
   logic [DW-1:0]         remd_ff, remd_in, dsh_ff, dsh_in;
   logic [30:0]           q_ff, q_in;
   logic signed [31:0]    s_ff, s_in;
   logic signed [62:0]    rprod_ff, rprod_in;
   logic signed [64:0]    mprod_ff, mprod_in;
   logic                  rv_ff, rv_in, rc_ff, rc_in;
   logic signed [31:0]    rt_ff, rt_in;

   // Scratch values of the datapath.
   logic [64:0]           add_p, add_q;
   logic [127:0]          disc;
   logic                  opp_sign;
   logic [66:0]           sq_r2, sq_trial;
   logic                  sq_ge, dv_ge, ok1, pass;
   logic [62:0]           sq_root;
   logic signed [NW-1:0]  np, nm, n_sel;
   logic [NW-1:0]         un, ud;
   logic [DW-1:0]         n_sh;
   logic [30:0]           m_q;
   logic signed [31:0]    s_div;
   logic signed [63:0]    rsum;
   logic signed [31:0]    r_edge;
   logic signed [32:0]    d_span;
   logic signed [65:0]    t_wide;
   logic                  done_div;

   always_comb begin
      state_in = state_ff;   radial_in = radial_ff;
      a_in = a_ff;   bp_in = bp_ff;   c_in = c_ff;   r0_in = r0_ff;   dr_in = dr_ff;
      mp_in = mp_ff; mq_in = mq_ff; mm_in = mm_ff; mn_in = mn_ff;  cnt_in = cnt_ff;
      sqn_in = sqn_ff;  rem_in = rem_ff;  root_in = root_ff;
      num0_in = num0_ff; num1_in = num1_ff; den_in = den_ff;
      two_in = two_ff; cidx_in = cidx_ff; neg_in = neg_ff;
      remd_in = remd_ff; dsh_in = dsh_ff; q_in = q_ff; s_in = s_ff;
      rprod_in = rprod_ff; mprod_in = mprod_ff;
      rv_in = 1'b0; rc_in = rc_ff; rt_in = rt_ff;
      q_pop = 1'b0;
      done_div = 1'b0;

      add_p    = {1'b0, mp_ff[127:64]} + (mp_ff[0] ? {1'b0, mm_ff} : 65'd0);
      add_q    = {1'b0, mq_ff[127:64]} + (mq_ff[0] ? {1'b0, mn_ff} : 65'd0);
      opp_sign = (a_ff[63] != c_ff[63]) || (c_ff == '0);
      disc     = opp_sign ? (mp_ff + mq_ff) : (mp_ff - mq_ff);

      sq_r2    = {rem_ff[64:0], sqn_ff[125:124]};
      sq_trial = {2'b00, root_ff, 2'b01};
      sq_ge    = (sq_r2 >= sq_trial);
      sq_root  = {root_ff[61:0], sq_ge};
      np       = NW'(bp_ff) + NW'(sq_root);
      nm       = NW'(bp_ff) - NW'(sq_root);

      n_sel    = cidx_ff ? num1_ff : num0_ff;
      un       = n_sel[NW-1] ? NW'(-n_sel) : NW'(n_sel);
      ud       = den_ff[NW-1] ? NW'(-den_ff) : NW'(den_ff);
      n_sh     = DW'(un) << FRAC_BITS;

      dv_ge    = (remd_ff >= dsh_ff);
      m_q      = {q_ff[29:0], dv_ge};
      s_div    = neg_ff ? -$signed({1'b0, m_q}) : $signed({1'b0, m_q});

      rsum     = (64'(r0_ff) <<< FRAC_BITS) + 64'(rprod_ff);
      ok1      = !rsum[63];
      r_edge   = 32'(r0_ff) + 32'(dr_ff);
      pass     = 1'b0;

      d_span   = 33'(cfg.dom_hi) - 33'(cfg.dom_lo);
      t_wide   = 66'(cfg.dom_lo) + 66'(mprod_ff >>> FRAC_BITS);

      unique case (state_ff)
         ST_IDLE: begin
            if (!q_empty) begin
               q_pop    = 1'b1;
               state_in = ST_LOAD;
            end
         end
         ST_LOAD: begin
            radial_in = q_data.radial;
            a_in  = q_data.a;   bp_in = q_data.bp;   c_in = q_data.c;
            r0_in = q_data.r0;  dr_in = q_data.dr;
            cidx_in = 1'b0;
            two_in  = 1'b0;
            if (!q_data.radial) begin
               num0_in = NW'(q_data.bp);
               den_in  = NW'(q_data.a);
               if (q_data.a == '0) begin
                  s_in     = '0;
                  state_in = ST_MAP1;
               end else if (q_data.bp < 0) begin
                  s_in     = '0;
                  state_in = cfg.mode[1] ? ST_MAP1 : ST_IDLE;
                  rv_in    = !cfg.mode[1];
               end else if (q_data.bp > q_data.a) begin
                  s_in     = S_ONE;
                  state_in = cfg.mode[2] ? ST_MAP1 : ST_IDLE;
                  rv_in    = !cfg.mode[2];
               end else begin
                  state_in = ST_DSAT;
               end
               rc_in = 1'b0;
               rt_in = '0;
            end else if (q_data.a == '0) begin
               num0_in = NW'(q_data.c);
               den_in  = NW'(q_data.bp) <<< 1;
               rc_in   = 1'b0;
               rt_in   = '0;
               if (q_data.bp == '0) begin
                  rv_in    = 1'b1;
                  state_in = ST_IDLE;
               end else begin
                  state_in = ST_DSAT;
               end
            end else begin
               mm_in    = q_data.bp[63] ? 64'(-q_data.bp) : 64'(q_data.bp);
               mp_in    = {64'd0, mm_in};
               mn_in    = q_data.a[63] ? 64'(-q_data.a) : 64'(q_data.a);
               mq_in    = {64'd0, (q_data.c[63] ? 64'(-q_data.c) : 64'(q_data.c))};
               cnt_in   = '0;
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            mp_in  = {add_p, mp_ff[63:1]};
            mq_in  = {add_q, mq_ff[63:1]};
            cnt_in = cnt_ff + 1'b1;
            if (cnt_ff == 7'd63) begin
               state_in = ST_DISC;
            end
         end
         ST_DISC: begin
            sqn_in  = disc[125:0];
            rem_in  = '0;
            root_in = '0;
            cnt_in  = '0;
            if (!opp_sign && (mp_ff < mq_ff)) begin
               rv_in    = 1'b1;
               rc_in    = 1'b0;
               rt_in    = '0;
               state_in = ST_IDLE;
            end else begin
               state_in = ST_SQRT;
            end
         end
         ST_SQRT: begin
            rem_in  = sq_ge ? (sq_r2 - sq_trial) : sq_r2;
            root_in = sq_root;
            sqn_in  = {sqn_ff[123:0], 2'b00};
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 7'd62) begin
               num0_in  = a_ff[63] ? nm : np;
               num1_in  = a_ff[63] ? np : nm;
               den_in   = NW'(a_ff);
               two_in   = 1'b1;
               cidx_in  = 1'b0;
               state_in = ST_DSAT;
            end
         end
         ST_DSAT: begin
            neg_in  = n_sel[NW-1] ^ den_ff[NW-1];
            remd_in = n_sh;
            dsh_in  = DW'(ud) << 30;
            q_in    = '0;
            cnt_in  = '0;
            if (ud == '0) begin
               s_in     = '0;
               done_div = 1'b1;
            end else if (n_sh >= (DW'(ud) << 31)) begin
               s_in     = (n_sel[NW-1] ^ den_ff[NW-1]) ? -S_MAX : S_MAX;
               done_div = 1'b1;
            end else begin
               state_in = ST_DLOOP;
            end
         end
         ST_DLOOP: begin
            remd_in = dv_ge ? (remd_ff - dsh_ff) : remd_ff;
            dsh_in  = dsh_ff >> 1;
            q_in    = m_q;
            cnt_in  = cnt_ff + 1'b1;
            if (cnt_ff == 7'd30) begin
               s_in     = s_div;
               done_div = 1'b1;
            end
         end
         ST_CHK1: begin
            rprod_in = s_ff * dr_ff;
            state_in = ST_CHK2;
         end
         ST_CHK2: begin
            if (ok1) begin
               if (s_ff[31]) begin
                  pass = cfg.mode[1] && !r0_ff[30];
                  s_in = '0;
               end else if (s_ff > S_ONE) begin
                  pass = cfg.mode[2] && !r_edge[31];
                  s_in = S_ONE;
               end else begin
                  pass = 1'b1;
               end
            end
            if (pass) begin
               state_in = ST_MAP1;
            end else if (two_ff && !cidx_ff) begin
               cidx_in  = 1'b1;
               state_in = ST_DSAT;
            end else begin
               rv_in    = 1'b1;
               rc_in    = 1'b0;
               rt_in    = '0;
               state_in = ST_IDLE;
            end
         end
         ST_MAP1: begin
            mprod_in = s_ff * d_span;
            state_in = ST_MAP2;
         end
         ST_MAP2: begin
            rv_in = 1'b1;
            rc_in = 1'b1;
            if (t_wide > 66'sd2147483647) begin
               rt_in = S_MAX;
            end else if (t_wide < -66'sd2147483648) begin
               rt_in = 32'sh8000_0000;
            end else begin
               rt_in = t_wide[31:0];
            end
            state_in = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (done_div) begin
         state_in = radial_ff ? ST_CHK1 : ST_MAP1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         rv_ff    <= rv_in;
      end
      radial_ff <= radial_in;
      a_ff <= a_in;   bp_ff <= bp_in;   c_ff <= c_in;   r0_ff <= r0_in;   dr_ff <= dr_in;
      mp_ff <= mp_in; mq_ff <= mq_in;   mm_ff <= mm_in; mn_ff <= mn_in;   cnt_ff <= cnt_in;
      sqn_ff <= sqn_in; rem_ff <= rem_in; root_ff <= root_in;
      num0_ff <= num0_in; num1_ff <= num1_in; den_ff <= den_in;
      two_ff <= two_in; cidx_ff <= cidx_in; neg_ff <= neg_in;
      remd_ff <= remd_in; dsh_ff <= dsh_in; q_ff <= q_in; s_ff <= s_in;
      rprod_ff <= rprod_in; mprod_ff <= mprod_in;
      rc_ff <= rc_in; rt_ff <= rt_in;
   end

   assign rsp_valid   = rv_ff;
   assign rsp_param_t = rt_ff;
   assign rsp_covered = rc_ff;

endmodule

// File: rtl/core/gradient_parameter_eval.sv
// Gradient parameter of an axial or radial shading at one point of shading space.
// A point is transferred in on req_point_x and req_point_y at a rising edge where start
// is high and busy is low. Each point gives exactly one result, shown for a single
// cycle with rsp_valid high: rsp_param_t (signed fixed point, saturated) and
// rsp_covered, which is low when the point lies outside the shading (rsp_param_t is
// then zero). The receiver cannot hold a result back, so results leave in order.
// The geometry registers are written over the csr_ channel, which is always ready;
// they must only change while no point is in flight.
// The front end takes one point per cycle while busy is low and classifies it in three
// pipeline stages; its items wait in an eight-entry queue. busy rises once eight
// points are held between the input and the back end, and falls as soon as the back
// end takes one. The back end evaluates one point at a time. An axial point's
// back-end time is set by the 31-step serial divider; a radial point's by the 64-step
// serial multiplier, the 63-step square root and the divider, which runs again when
// the larger root is rejected. Latency is the front end's pipeline plus the queue
// wait plus that back-end time.
// Synchronous reset empties the pipeline and queue and restores the register defaults.
module gradient_parameter_eval import gpe_pkg::*; #(
   parameter int FRAC_BITS = FRAC_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   output logic               busy,
   input  logic signed [31:0] req_point_x,
   input  logic signed [31:0] req_point_y,
   output logic               rsp_valid,
   output logic signed [31:0] rsp_param_t,
   output logic               rsp_covered,
   input  logic               csr_valid,
   output logic               csr_ready,
   input  logic [7:0]         csr_index,
   input  logic [63:0]        csr_data
);

   localparam int CRW = $clog2(QUEUE_DEPTH + 1);

   gpe_cfg_type   cfg_ff, cfg_in;
   logic [CRW-1:0] credit_ff, credit_in;
   logic          accept, csr_write, q_pop, q_empty, item_valid;
   gpe_item_type  item, q_data;

   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;
   assign busy      = (credit_ff == CRW'(QUEUE_DEPTH));
   assign accept    = start && !busy;

   // Configuration register file; indexes past the list are dropped.
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_MODE:   cfg_in.mode    = csr_data[2:0];
            CSR_STRT_X: cfg_in.start_x = csr_data[31:0];
            CSR_STRT_Y: cfg_in.start_y = csr_data[31:0];
            CSR_STRT_R: cfg_in.start_r = csr_data[31:0];
            CSR_END_X:  cfg_in.end_x   = csr_data[31:0];
            CSR_END_Y:  cfg_in.end_y   = csr_data[31:0];
            CSR_END_R:  cfg_in.end_r   = csr_data[31:0];
            CSR_DOMAIN: begin
               cfg_in.dom_lo = csr_data[31:0];
               cfg_in.dom_hi = csr_data[63:32];
            end
            default: begin
            end
         endcase
      end
   end

   // A credit is taken for every point accepted and returned when the back end
   // pulls an item from the queue, so the queue can never overflow.
   assign credit_in = credit_ff + CRW'(accept) - CRW'(q_pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '{mode: '0, start_x: '0, start_y: '0, start_r: '0,
                        end_x: 32'sd65536, end_y: '0, end_r: '0,
                        dom_lo: '0, dom_hi: 32'sd65536};
         credit_ff <= '0;
      end else begin
         cfg_ff         <= cfg_in;
         credit_ff      <= credit_in;
      end
   end

   gpe_front u_front (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .point_x    (req_point_x),
      .point_y    (req_point_y),
      .cfg        (cfg_ff),
      .item_valid (item_valid),
      .item       (item)
   );

   gpe_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (item_valid),
      .push_data (item),
      .pop       (q_pop),
      .empty     (q_empty),
      .rd_data   (q_data)
   );

   gpe_back #(
      .FRAC_BITS (FRAC_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .q_empty     (q_empty),
      .q_data      (q_data),
      .q_pop       (q_pop),
      .rsp_valid   (rsp_valid),
      .rsp_param_t (rsp_param_t),
      .rsp_covered (rsp_covered)
   );

endmodule

// File: dv/tb_gradient_parameter_eval.sv
`timescale 1ns / 100ps

module tb_gradient_parameter_eval;
   import gpe_pkg::*;

   // Fixed-point layout of the block as instantiated here.
   localparam int      FRAC       = FRAC_BITS_DEF;
   localparam longint  ONE_FIX    = longint'(1) << FRAC;
   localparam longint  S_MAX      = 64'sd2147483647;
   localparam longint  OPND_LIM   = longint'(1) << 30;
   localparam int      CYCLE_CAP  = 2_000_000;
   localparam int      N_PHASES   = 10;
   localparam int      PHASE_LEN  = 200;
   localparam int      N_DIRECTED = 27;

   // An index past the register file; the block must ignore writes to it.
   localparam logic [7:0] CSR_SPARE = 8'd9;

   // Mode register bits.
   localparam logic [2:0] MODE_RADIAL = 3'b001;
   localparam logic [2:0] MODE_EXT_LO = 3'b010;
   localparam logic [2:0] MODE_EXT_HI = 3'b100;

   typedef struct {
      logic signed [31:0] t;
      logic               cov;
   } shade_res_type;

   // One row of the directed part: either a register write or a point.  Where
   // the outcome is obvious it is written out, otherwise the predictor decides.
   typedef struct {
      bit                 is_csr;
      logic [7:0]         idx;
      logic [63:0]        data;
      logic signed [31:0] x;
      logic signed [31:0] y;
      bit                 known;
      logic signed [31:0] t;
      bit                 cov;
   } dir_row_type;

   logic               clock;
   logic               reset;
   logic               start;
   logic               busy;
   logic signed [31:0] req_point_x;
   logic signed [31:0] req_point_y;
   logic               rsp_valid;
   logic signed [31:0] rsp_param_t;
   logic               rsp_covered;
   logic               csr_valid;
   logic               csr_ready;
   logic [7:0]         csr_index;
   logic [63:0]        csr_data;

   // The predictor's own copy of the shading registers.
   gpe_cfg_type   shade_cfg;
   shade_res_type shade_pending [$];
   int            fail_count;
   int            cycle_count;
   dir_row_type   dir_tbl [N_DIRECTED];

   gradient_parameter_eval i_dut (
      .clock       (clock),
      .reset       (reset),
      .start       (start),
      .busy        (busy),
      .req_point_x (req_point_x),
      .req_point_y (req_point_y),
      .rsp_valid   (rsp_valid),
      .rsp_param_t (rsp_param_t),
      .rsp_covered (rsp_covered),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   // A hard ceiling on the run, so that a hung handshake cannot stall it for ever.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_CAP) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Predictor.  All geometry runs on 64-bit signed integers; only the radial
   // discriminant, its square root and the fixed-point quotient need 128 bits.
   // ---------------------------------------------------------------------------

   function automatic logic [63:0] magn(longint v);
      return (v < 0) ? 64'(-v) : 64'(v);
   endfunction

   // Quotient n/d as a fixed-point value, truncated towards zero and saturated.
   function automatic longint fix_div(longint n, longint d);
      logic [63:0]  un, ud, q;
      logic [127:0] m;
      un = magn(n);
      ud = magn(d);
      if (ud == 0) return 0;
      q = un / ud;
      if (q > (64'(S_MAX) >> FRAC)) m = 128'(S_MAX);
      else m = ({64'd0, un} << FRAC) / {64'd0, ud};
      return ((n < 0) != (d < 0)) ? -longint'(m[63:0]) : longint'(m[63:0]);
   endfunction

   function automatic logic [63:0] floor_sqrt(logic [127:0] v);
      logic [63:0] r, c;
      r = 0;
      for (int b = 62; b >= 0; b--) begin
         c = r | (64'd1 << b);
         if ({64'd0, c} * {64'd0, c} <= v) r = c;
      end
      return r;
   endfunction

   // All operands share one right shift (floor), the smallest that brings
   // every one of them into the 31-bit signed range, but never more than two.
   function automatic void shrink_operands(ref longint v [6], input int n);
      int k;
      bit fits;
      k = 0;
      fits = 1'b0;
      while (!fits && k < 2) begin
         fits = 1'b1;
         for (int i = 0; i < n; i++)
            if ((v[i] >>> k) < -OPND_LIM || (v[i] >>> k) >= OPND_LIM) fits = 1'b0;
         if (!fits) k++;
      end
      for (int i = 0; i < n; i++) v[i] = v[i] >>> k;
   endfunction

   function automatic bit radius_nonneg(longint r0, longint dr, longint s);
      return (r0 * ONE_FIX + s * dr) >= 0;
   endfunction

   function automatic bit axial_s(longint px, longint py, output longint s);
      longint v [6];
      longint num, den;
      v[0] = longint'(shade_cfg.end_x) - longint'(shade_cfg.start_x);
      v[1] = longint'(shade_cfg.end_y) - longint'(shade_cfg.start_y);
      v[2] = px - longint'(shade_cfg.start_x);
      v[3] = py - longint'(shade_cfg.start_y);
      v[4] = 0;
      v[5] = 0;
      shrink_operands(v, 4);
      den = v[0] * v[0] + v[1] * v[1];
      num = v[2] * v[0] + v[3] * v[1];
      s = 0;
      // A segment of zero length puts every point at the start.
      if (den == 0) return 1'b1;
      if (num < 0) return (shade_cfg.mode & MODE_EXT_LO) != 0;
      if (num > den) begin
         s = ONE_FIX;
         return (shade_cfg.mode & MODE_EXT_HI) != 0;
      end
      s = fix_div(num, den);
      return 1'b1;
   endfunction

   function automatic bit radial_s(longint px, longint py, output longint s);
      longint       v [6];
      longint       a, bp, c, sq, np, nm, cs;
      longint       cand [2];
      logic [127:0] b2, ac, disc;
      int           n;
      bit           have;
      v[0] = longint'(shade_cfg.end_x) - longint'(shade_cfg.start_x);
      v[1] = longint'(shade_cfg.end_y) - longint'(shade_cfg.start_y);
      v[2] = longint'(shade_cfg.end_r) - longint'(shade_cfg.start_r);
      v[3] = px - longint'(shade_cfg.start_x);
      v[4] = py - longint'(shade_cfg.start_y);
      v[5] = longint'(shade_cfg.start_r);
      shrink_operands(v, 6);
      a  = v[0] * v[0] + v[1] * v[1] - v[2] * v[2];
      bp = v[3] * v[0] + v[4] * v[1] + v[5] * v[2];
      c  = v[3] * v[3] + v[4] * v[4] - v[5] * v[5];
      n  = 0;
      s  = 0;
      if (a == 0) begin
         // Linear case; no root at all when the linear term vanishes too.
         if (bp != 0) begin
            cand[0] = fix_div(c, 2 * bp);
            n = 1;
         end
      end else begin
         b2   = {64'd0, magn(bp)} * {64'd0, magn(bp)};
         ac   = {64'd0, magn(a)} * {64'd0, magn(c)};
         have = 1'b1;
         disc = b2;
         if ((a < 0) != (c < 0) || c == 0) disc = b2 + ac;
         else if (b2 < ac) have = 1'b0;
         else disc = b2 - ac;
         if (have) begin
            sq = longint'(floor_sqrt(disc));
            np = bp + sq;
            nm = bp - sq;
            cand[0] = fix_div((a > 0) ? np : nm, a);
            cand[1] = fix_div((a > 0) ? nm : np, a);
            n = 2;
         end
      end
      // The larger root is tried first; each must keep a non-negative radius
      // both before and after clamping.
      for (int i = 0; i < n; i++) begin
         cs = cand[i];
         if (!radius_nonneg(v[5], v[2], cs)) continue;
         if (cs < 0) begin
            if ((shade_cfg.mode & MODE_EXT_LO) == 0) continue;
            cs = 0;
         end else if (cs > ONE_FIX) begin
            if ((shade_cfg.mode & MODE_EXT_HI) == 0) continue;
            cs = ONE_FIX;
         end
         if (!radius_nonneg(v[5], v[2], cs)) continue;
         s = cs;
         return 1'b1;
      end
      return 1'b0;
   endfunction

   function automatic shade_res_type shade_param(logic signed [31:0] px,
                                                  logic signed [31:0] py);
      shade_res_type r;
      longint        s, d0, d1, t;
      bit            ok;
      if ((shade_cfg.mode & MODE_RADIAL) != 0) ok = radial_s(px, py, s);
      else ok = axial_s(px, py, s);
      d0 = longint'(shade_cfg.dom_lo);
      d1 = longint'(shade_cfg.dom_hi);
      t  = d0 + ((s * (d1 - d0)) >>> FRAC);
      if (t > S_MAX) t = S_MAX;
      if (t < -S_MAX - 1) t = -S_MAX - 1;
      r.t   = ok ? 32'(t) : 32'sd0;
      r.cov = ok;
      return r;
   endfunction

   function automatic void shade_csr(logic [7:0] idx, logic [63:0] data);
      case (idx)
         CSR_MODE:   shade_cfg.mode    = data[2:0];
         CSR_STRT_X: shade_cfg.start_x = data[31:0];
         CSR_STRT_Y: shade_cfg.start_y = data[31:0];
         CSR_STRT_R: shade_cfg.start_r = data[31:0];
         CSR_END_X:  shade_cfg.end_x   = data[31:0];
         CSR_END_Y:  shade_cfg.end_y   = data[31:0];
         CSR_END_R:  shade_cfg.end_r   = data[31:0];
         CSR_DOMAIN: begin
            shade_cfg.dom_lo = data[31:0];
            shade_cfg.dom_hi = data[63:32];
         end
         default: ;
      endcase
   endfunction

   // ---------------------------------------------------------------------------
   // Drivers.  Every task is entered and left on a rising edge, and all inputs
   // change by nonblocking assignment on that edge.
   // ---------------------------------------------------------------------------

   // Sends one point after an idle gap.  start stays high on leaving, so that
   // the next point can follow in the very next cycle.
   task automatic send_point(logic signed [31:0] px, logic signed [31:0] py, int gap,
                             bit known, shade_res_type kres);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start       <= 1'b1;
      req_point_x <= px;
      req_point_y <= py;
      @(posedge clock);
      while (busy) @(posedge clock);
      // The transfer has happened on this edge: record what must come out.
      shade_pending.push_back(known ? kres : shade_param(px, py));
   endtask

   // Waits until every result in flight has been checked, then lets a few more
   // cycles go by so that the block is fully quiet before a register changes.
   task automatic drain;
      start <= 1'b0;
      @(posedge clock);
      while (shade_pending.size() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_csr(logic [7:0] idx, logic [63:0] data);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      shade_csr(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   // Idle gaps are mostly absent or short, with the odd long one.
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 95) return $urandom_range(1, 3);
      return $urandom_range(20, 300);
   endfunction

   function automatic logic signed [31:0] pick_coord(bit wide);
      int r;
      r = $urandom_range(0, 99);
      if (wide || r < 8) return $urandom;
      if (r < 12) begin
         case ($urandom_range(0, 3))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'sd0;
            default: return -32'sd1;
         endcase
      end
      return int'($urandom_range(0, 32'h0010_0000)) - 32'sh0008_0000;
   endfunction

   function automatic logic signed [31:0] pick_radius();
      if ($urandom_range(0, 9) == 0) return -int'($urandom_range(0, 32'h0002_0000));
      return $urandom_range(0, 32'h0004_0000);
   endfunction

   // ---------------------------------------------------------------------------
   // Result checker.  The block cannot hold results back, so each strobe is
   // compared at once with the oldest outstanding expectation.
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      shade_res_type want;
      if (!reset && rsp_valid) begin
         if (shade_pending.size() == 0) begin
            $error("result with nothing outstanding: param_t %0d covered %0b",
                   rsp_param_t, rsp_covered);
            fail_count++;
         end else begin
            want = shade_pending.pop_front();
            if (rsp_param_t !== want.t) begin
               $error("param_t: expected %0d, got %0d", want.t, rsp_param_t);
               fail_count++;
            end
            if (rsp_covered !== want.cov) begin
               $error("covered: expected %0b, got %0b", want.cov, rsp_covered);
               fail_count++;
            end
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus.
   // ---------------------------------------------------------------------------
   initial begin
      shade_res_type kres;
      logic [63:0]   dom;
      bit            wide;
      logic [2:0]    mode;

      fail_count  = 0;
      cycle_count = 0;
      reset       = 1'b1;
      start       = 1'b0;
      req_point_x = '0;
      req_point_y = '0;
      csr_valid   = 1'b0;
      csr_index   = '0;
      csr_data    = '0;

      // Register defaults after reset: axial, unit segment along x, domain 0..1.
      shade_cfg         = '0;
      shade_cfg.end_x   = 32'sh0001_0000;
      shade_cfg.dom_hi  = 32'sh0001_0000;

      // Directed rows.  With the reset geometry s equals x in fixed point, so the
      // first rows can be written out by hand; points outside the segment are not
      // covered until the extend bits are set.
      dir_tbl = '{
         '{0, 0, 0, 32'sd0, 32'sd0, 1, 32'sd0, 1},
         '{0, 0, 0, 32'sh0001_0000, 32'sd0, 1, 32'sh0001_0000, 1},
         '{0, 0, 0, 32'sh0000_8000, 32'sd12345, 1, 32'sh0000_8000, 1},
         '{0, 0, 0, -32'sd1, 32'sd0, 1, 32'sd0, 0},
         '{0, 0, 0, 32'sh0002_0000, 32'sd0, 1, 32'sd0, 0},
         '{0, 0, 0, 32'h8000_0000, 32'h8000_0000, 1, 32'sd0, 0},
         '{0, 0, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'sd0, 0},
         '{1, CSR_MODE, 64'(MODE_EXT_LO | MODE_EXT_HI), 0, 0, 0, 0, 0},
         '{0, 0, 0, -32'sd1, 32'sd0, 1, 32'sd0, 1},
         '{0, 0, 0, 32'h7FFF_FFFF, 32'sd0, 1, 32'sh0001_0000, 1},
         // Widest possible domain, to push t into saturation.
         '{1, CSR_DOMAIN, 64'h7FFF_FFFF_8000_0000, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'h7FFF_FFFF, 32'sd0, 0, 0, 0},
         '{0, 0, 0, 32'sh0000_4000, 32'h8000_0000, 0, 0, 0},
         // Start and end coincide: the degenerate axis.
         '{1, CSR_END_X, 64'd0, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'sh0000_4000, 32'sh0003_0000, 0, 0, 0},
         // Radial cone growing from a point; the origin hits the zero-radius apex.
         '{1, CSR_MODE, 64'(MODE_RADIAL), 0, 0, 0, 0, 0},
         '{1, CSR_END_X, 64'h0000_0000_0004_0000, 0, 0, 0, 0, 0},
         '{1, CSR_END_R, 64'h0000_0000_0002_0000, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'sd0, 32'sd0, 0, 0, 0},
         '{0, 0, 0, 32'sh0002_0000, 32'sh0000_8000, 0, 0, 0},
         '{0, 0, 0, 32'sh0000_0000, 32'sh0009_0000, 0, 0, 0},
         // Centre distance equal to the radius change: the quadratic term vanishes.
         '{1, CSR_END_X, 64'h0000_0000_0003_0000, 0, 0, 0, 0, 0},
         '{1, CSR_END_Y, 64'h0000_0000_0004_0000, 0, 0, 0, 0, 0},
         '{1, CSR_END_R, 64'h0000_0000_0005_0000, 0, 0, 0, 0, 0},
         '{0, 0, 0, 32'sh0001_0000, 32'sh0001_0000, 0, 0, 0},
         // A negative starting radius, and a write that no register answers to.
         '{1, CSR_STRT_R, 64'h0000_0000_FFFF_0000, 0, 0, 0, 0, 0},
         '{1, CSR_SPARE, 64'hFFFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0}
      };

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_tbl[i]) begin
         if (dir_tbl[i].is_csr) begin
            drain();
            write_csr(dir_tbl[i].idx, dir_tbl[i].data);
         end else begin
            kres.t   = dir_tbl[i].t;
            kres.cov = dir_tbl[i].cov;
            send_point(dir_tbl[i].x, dir_tbl[i].y, pick_gap(), dir_tbl[i].known, kres);
         end
      end
      send_point(32'sh0000_C000, -32'sh0000_4000, 0, 0, kres);
      send_point(32'h8000_0000, 32'h7FFF_FFFF, 0, 0, kres);

      // Random phases.  The first two use the extreme register values; most
      // others keep the geometry within a few units so that the points fall on
      // and around the shading, and every fourth one spans the full range.
      for (int ph = 0; ph < N_PHASES; ph++) begin
         drain();
         wide = (ph % 4 == 3);
         if (ph == 0) begin
            write_csr(CSR_MODE,   64'd7);
            write_csr(CSR_STRT_X, 64'h7FFF_FFFF);
            write_csr(CSR_STRT_Y, 64'h7FFF_FFFF);
            write_csr(CSR_STRT_R, 64'h7FFF_FFFF);
            write_csr(CSR_END_X,  64'h8000_0000);
            write_csr(CSR_END_Y,  64'h8000_0000);
            write_csr(CSR_END_R,  64'h8000_0000);
            write_csr(CSR_DOMAIN, 64'hFFFF_FFFF_FFFF_FFFF);
         end else if (ph == 1) begin
            write_csr(CSR_MODE,   64'd0);
            write_csr(CSR_STRT_X, 64'h8000_0000);
            write_csr(CSR_STRT_Y, 64'h8000_0000);
            write_csr(CSR_END_X,  64'h7FFF_FFFF);
            write_csr(CSR_END_Y,  64'h7FFF_FFFF);
            write_csr(CSR_DOMAIN, 64'h8000_0000_7FFF_FFFF);
         end else begin
            mode = $urandom_range(0, 7);
            write_csr(CSR_MODE,   64'(mode));
            write_csr(CSR_STRT_X, 64'(pick_coord(wide)));
            write_csr(CSR_STRT_Y, 64'(pick_coord(wide)));
            write_csr(CSR_STRT_R, 64'(wide ? 32'($urandom) : pick_radius()));
            write_csr(CSR_END_X,  64'(pick_coord(wide)));
            write_csr(CSR_END_Y,  64'(pick_coord(wide)));
            write_csr(CSR_END_R,  64'(wide ? 32'($urandom) : pick_radius()));
            if ($urandom_range(0, 2) == 0) dom = {$urandom, $urandom};
            else dom = {32'($urandom_range(0, 32'h0004_0000)),
                        32'(-int'($urandom_range(0, 32'h0004_0000)))};
            write_csr(CSR_DOMAIN, dom);
         end
         for (int n = 0; n < PHASE_LEN; n++) begin
            // Now and then the sender holds off until the block has emptied.
            if (n == PHASE_LEN / 2 && ph % 2 == 0) drain();
            send_point(pick_coord(wide), pick_coord(wide), pick_gap(), 0, kres);
         end
      end

      drain();
      repeat (300) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule
